FILE: rtl/gni_pkg.sv
`default_nettype none
package gni_pkg;

   localparam int ROW_W    = 30;
   localparam int DELTA_W  = 12;
   localparam int EXT_W    = 11;
   localparam int COORD_W  = 10;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int DEF_MAX_EXTENT = 1024;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXTENT_X = 2'd0,
      CSR_EXTENT_Y = 2'd1,
      CSR_EXTENT_Z = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_BAD_ROW      = 2'd1,
      ST_BAD_NEIGHBOR = 2'd2
   } status_type;

   typedef struct packed {
      logic [ROW_W-1:0]          row;
      logic signed [DELTA_W-1:0] delta_i;
      logic signed [DELTA_W-1:0] delta_j;
      logic signed [DELTA_W-1:0] delta_k;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] coord_i;
      logic [COORD_W-1:0] coord_j;
      logic [COORD_W-1:0] coord_k;
      logic [ROW_W-1:0]   neighbor_row;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Beat as it sits in the queue: request plus front-end classification.
   typedef struct packed {
      req_type req;
      logic    empty_grid;
   } item_type;

   typedef struct packed {
      logic [EXT_W-1:0] nx;
      logic [EXT_W-1:0] ny;
      logic [EXT_W-1:0] nz;
   } extents_type;

endpackage
`default_nettype wire

FILE: rtl/gni_front.sv
`default_nettype none
module gni_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire gni_pkg::req_type   req_data,
   input  wire gni_pkg::extents_type ext,
   output logic                    push,
   output gni_pkg::item_type       push_data,
   input  wire logic               queue_full
);
   import gni_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign push      = valid_ff && !queue_full;
   assign push_data = item_ff;
   assign req_ready = !valid_ff || !queue_full;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push) valid_in = 1'b0;
      if (req_valid && req_ready) begin
         valid_in           = 1'b1;
         item_in.req        = req_data;
         item_in.empty_grid = (ext.nx == '0) || (ext.ny == '0) || (ext.nz == '0);
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end
endmodule
`default_nettype wire

FILE: rtl/gni_queue.sv
`default_nettype none
module gni_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gni_pkg::item_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output gni_pkg::item_type      pop_data
);
   import gni_pkg::*;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type           mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;

   assign full      = cnt_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign pop_data  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_no_bad_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_no_bad_push: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push to full queue");
endmodule
`default_nettype wire

FILE: rtl/gni_div.sv
`default_nettype none
// Restoring divider, one quotient bit per stage, advances on adv.
module gni_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 11,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   input  wire logic [TAG_W-1:0] tag,
   output logic                  out_valid,
   output logic [NUM_W-1:0]      quo,
   output logic [DEN_W-1:0]      rem,
   output logic [TAG_W-1:0]      out_tag
);
   logic             v_ff   [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [TAG_W-1:0] tag_ff [NUM_W];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic             v_src;
      logic [DEN_W-1:0] r_src;
      logic [NUM_W-1:0] nq_src;
      logic [TAG_W-1:0] t_src;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W:0]   diff;

      if (s == 0) begin : g_first
         assign v_src = in_valid; assign r_src = '0;
         assign nq_src = num;     assign t_src = tag;
      end else begin : g_next
         assign v_src = v_ff[s-1]; assign r_src = rem_ff[s-1];
         assign nq_src = nq_ff[s-1]; assign t_src = tag_ff[s-1];
      end

      assign trial = {r_src, nq_src[NUM_W-1]};
      assign ge    = trial >= {1'b0, den};
      assign diff  = trial - {1'b0, den};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_ff[s]  <= {nq_src[NUM_W-2:0], ge};
            tag_ff[s] <= t_src;
         end
         if (reset)    v_ff[s] <= 1'b0;
         else if (adv) v_ff[s] <= v_src;
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign quo       = nq_ff[NUM_W-1];
   assign rem       = rem_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];
endmodule
`default_nettype wire

FILE: rtl/gni_back.sv
`default_nettype none
module gni_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gni_pkg::extents_type ext,
   input  wire logic                 q_not_empty,
   input  wire gni_pkg::item_type    q_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output gni_pkg::rsp_type          rsp_data
);
   import gni_pkg::*;

   localparam int D3_W   = 3 * DELTA_W;
   localparam int TAG1_W = D3_W + 1;
   localparam int TAG2_W = TAG1_W + COORD_W;
   localparam int SV_W   = COORD_W + 3;
   localparam int T_W    = 2 * EXT_W;

   logic adv;
   // Whole chain moves when the output slot is free or being taken.
   assign adv = !rsp_valid || rsp_ready;
   assign pop = adv && q_not_empty;

   // x split
   logic              d1_v;
   logic [ROW_W-1:0]  d1_q;
   logic [EXT_W-1:0]  d1_r;
   logic [TAG1_W-1:0] d1_t;

   gni_div #(.NUM_W(ROW_W), .DEN_W(EXT_W), .TAG_W(TAG1_W)) u_div_x (
      .clock, .reset, .adv, .in_valid(pop), .num(q_data.req.row), .den(ext.nx),
      .tag({q_data.req.delta_i, q_data.req.delta_j, q_data.req.delta_k,
            q_data.empty_grid}),
      .out_valid(d1_v), .quo(d1_q), .rem(d1_r), .out_tag(d1_t));

   // y/z split
   logic              d2_v;
   logic [ROW_W-1:0]  d2_q;
   logic [EXT_W-1:0]  d2_r;
   logic [TAG2_W-1:0] d2_t;

   gni_div #(.NUM_W(ROW_W), .DEN_W(EXT_W), .TAG_W(TAG2_W)) u_div_y (
      .clock, .reset, .adv, .in_valid(d1_v), .num(d1_q), .den(ext.ny),
      .tag({d1_t, d1_r[COORD_W-1:0]}),
      .out_valid(d2_v), .quo(d2_q), .rem(d2_r), .out_tag(d2_t));

   logic signed [DELTA_W-1:0] di, dj, dk;
   logic                      empty_grid;
   logic [COORD_W-1:0]        ci, cj;
   assign {di, dj, dk, empty_grid, ci} = d2_t;
   assign cj = d2_r[COORD_W-1:0];

   logic signed [SV_W-1:0] vi, vj, vk;
   logic bad_row, bad_nb;
   always_comb begin
      vi = $signed({3'b000, ci}) + SV_W'(di);
      vj = $signed({3'b000, cj}) + SV_W'(dj);
      vk = $signed({3'b000, d2_q[COORD_W-1:0]}) + SV_W'(dk);
      bad_row = empty_grid || (d2_q >= ROW_W'(ext.nz));
      bad_nb  = vi < 0 || vi >= $signed(SV_W'(ext.nx))
             || vj < 0 || vj >= $signed(SV_W'(ext.ny))
             || vk < 0 || vk >= $signed(SV_W'(ext.nz));
   end

   // stage A: bounds
   logic               a_v_ff;
   logic [COORD_W-1:0] a_ci_ff, a_cj_ff, a_ck_ff, a_ni_ff, a_nj_ff, a_nk_ff;
   status_type         a_st_ff;
   // stage B: nk*ny + nj
   logic               b_v_ff;
   logic [COORD_W-1:0] b_ci_ff, b_cj_ff, b_ck_ff, b_ni_ff;
   logic [T_W-1:0]     b_t_ff;
   status_type         b_st_ff;
   // stage C: output
   logic               c_v_ff;
   rsp_type            c_ff;

   logic [T_W-1:0]       t_in;
   logic [T_W+EXT_W-1:0] n_in;
   assign t_in = T_W'(a_nk_ff) * T_W'(ext.ny) + T_W'(a_nj_ff);
   assign n_in = (T_W+EXT_W)'(b_t_ff) * (T_W+EXT_W)'(ext.nx) + (T_W+EXT_W)'(b_ni_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ci_ff <= bad_row ? '0 : ci;
         a_cj_ff <= bad_row ? '0 : cj;
         a_ck_ff <= bad_row ? '0 : d2_q[COORD_W-1:0];
         a_ni_ff <= vi[COORD_W-1:0];
         a_nj_ff <= vj[COORD_W-1:0];
         a_nk_ff <= vk[COORD_W-1:0];
         a_st_ff <= bad_row ? ST_BAD_ROW : (bad_nb ? ST_BAD_NEIGHBOR : ST_OK);

         b_ci_ff <= a_ci_ff; b_cj_ff <= a_cj_ff; b_ck_ff <= a_ck_ff;
         b_ni_ff <= a_ni_ff; b_t_ff <= t_in; b_st_ff <= a_st_ff;

         c_ff.coord_i      <= b_ci_ff;
         c_ff.coord_j      <= b_cj_ff;
         c_ff.coord_k      <= b_ck_ff;
         c_ff.neighbor_row <= (b_st_ff == ST_OK) ? n_in[ROW_W-1:0] : '0;
         c_ff.status       <= b_st_ff;
      end
      if (reset) begin
         a_v_ff <= 1'b0; b_v_ff <= 1'b0; c_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= d2_v; b_v_ff <= a_v_ff; c_v_ff <= b_v_ff;
      end
   end

   assign rsp_valid = c_v_ff;
   assign rsp_data  = c_ff;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status code");
   a_zero_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.neighbor_row == '0)
      else $error("neighbor row not cleared");
   a_zero_coord: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_BAD_ROW |->
      rsp_data.coord_i == '0 && rsp_data.coord_j == '0 && rsp_data.coord_k == '0)
      else $error("coords not cleared on bad row");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
endmodule
`default_nettype wire

FILE: rtl/grid_neighbor_index.sv
`default_nettype none
// channel | direction | beat          | handshake
// req     | in        | row, deltas   | req_valid / req_ready
// rsp     | out       | coords, row   | rsp_valid / rsp_ready
// csr     | in        | extent write  | csr_we, no wait
//
// One beat per cycle sustained while rsp is not stalled. Path: 1 front
// register, queue, 60 divider stages (30 for the x split, 30 for the y/z
// split), then bounds, multiply and multiply-add stages.
// Reset (synchronous) empties every stage and sets all extents to 1.
// A stalled rsp freezes the back pipeline; the 4-deep queue plus the front
// register keep req_ready high for a few more beats.
module grid_neighbor_index (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire gni_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output gni_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [gni_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gni_pkg::EXT_W-1:0]     csr_wdata
);
   import gni_pkg::*;

   extents_type      ext_ff, ext_in;
   logic [EXT_W-1:0] sat_val;

   // Values above the largest extent saturate on write.
   assign sat_val = (csr_wdata > EXT_W'(DEF_MAX_EXTENT)) ? EXT_W'(DEF_MAX_EXTENT)
                                                        : csr_wdata;

   always_comb begin
      ext_in = ext_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EXTENT_X: ext_in.nx = sat_val;
            CSR_EXTENT_Y: ext_in.ny = sat_val;
            CSR_EXTENT_Z: ext_in.nz = sat_val;
            default: ;  // unmapped index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ext_ff <= '{nx: EXT_W'(1), ny: EXT_W'(1), nz: EXT_W'(1)};
      else       ext_ff <= ext_in;
   end

   logic     push, full, pop, not_empty;
   item_type push_data, pop_data;

   gni_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data, .ext(ext_ff),
      .push, .push_data, .queue_full(full));

   gni_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .not_empty, .pop_data);

   gni_back u_back (
      .clock, .reset, .ext(ext_ff), .q_not_empty(not_empty), .q_data(pop_data),
      .pop, .rsp_valid, .rsp_ready, .rsp_data);
endmodule
`default_nettype wire

FILE: tb/grid_neighbor_checker.sv
module grid_neighbor_checker
   import gni_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [EXT_W-1:0]     csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   logic [EXT_W-1:0] ext_x, ext_y, ext_z;
   rsp_type          lookups_due[$];

   function automatic logic [EXT_W-1:0] clamp_extent(logic [EXT_W-1:0] v);
      return (v > DEF_MAX_EXTENT) ? EXT_W'(DEF_MAX_EXTENT) : v;
   endfunction

   function automatic rsp_type neighbor_lookup(req_type r);
      longint nx, ny, nz, i, j, k, ni, nj, nk;
      rsp_type p;
      nx = ext_x;
      ny = ext_y;
      nz = ext_z;
      p = '0;
      p.status = ST_BAD_ROW;
      if (nx == 0 || ny == 0 || nz == 0 || longint'(r.row) >= nx * ny * nz) return p;
      i = r.row % nx;
      j = (r.row / nx) % ny;
      k = r.row / (nx * ny);
      p.coord_i = COORD_W'(i);
      p.coord_j = COORD_W'(j);
      p.coord_k = COORD_W'(k);
      ni = i + longint'(r.delta_i);
      nj = j + longint'(r.delta_j);
      nk = k + longint'(r.delta_k);
      if (ni < 0 || ni >= nx || nj < 0 || nj >= ny || nk < 0 || nk >= nz) begin
         p.status = ST_BAD_NEIGHBOR;
         return p;
      end
      p.neighbor_row = ROW_W'((nk * ny + nj) * nx + ni);
      p.status = ST_OK;
      return p;
   endfunction

   assign pending = lookups_due.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ext_x <= 1;
         ext_y <= 1;
         ext_z <= 1;
         lookups_due.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            lookups_due.insert(lookups_due.size(), neighbor_lookup(req_data));
         if (rsp_valid && rsp_ready) begin
            if (lookups_due.size() == 0) begin
               $error("result beat with no lookup outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = lookups_due.pop_front();
               if (rsp_data != want) fail_count <= fail_count + 1;
               if (rsp_data.coord_i != want.coord_i)
                  $error("coord_i expected %0d actual %0d", want.coord_i, rsp_data.coord_i);
               if (rsp_data.coord_j != want.coord_j)
                  $error("coord_j expected %0d actual %0d", want.coord_j, rsp_data.coord_j);
               if (rsp_data.coord_k != want.coord_k)
                  $error("coord_k expected %0d actual %0d", want.coord_k, rsp_data.coord_k);
               if (rsp_data.neighbor_row != want.neighbor_row)
                  $error("neighbor_row expected %0d actual %0d",
                         want.neighbor_row, rsp_data.neighbor_row);
               if (rsp_data.status != want.status)
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_EXTENT_X: ext_x <= clamp_extent(csr_wdata);
               CSR_EXTENT_Y: ext_y <= clamp_extent(csr_wdata);
               CSR_EXTENT_Z: ext_z <= clamp_extent(csr_wdata);
               default: ;
            endcase
         end
      end
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   import gni_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int RUN_LIMIT  = 300000;   // cycles; slowest correct run is far below
   localparam int DRAIN_WAIT = 100;      // settle time after the last result

   logic                 clock, reset;
   logic                 req_valid, req_ready;
   req_type              req_data;
   logic                 rsp_valid, rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [EXT_W-1:0]     csr_wdata;
   int                   fail_count, pending;
   int                   cycles = 0;
   logic                 no_idle;        // burst mode: neither side idles
   longint               cells;          // current grid size as the stimulus sees it
   longint               ex, ey, ez;

   grid_neighbor_index uut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   grid_neighbor_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stalls ~18% of cycles unless in a burst
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= no_idle || ($urandom_range(99) >= 18);
   end

   // one beat on req; valid held until accepted
   task automatic send_beat(req_type r);
      while (!no_idle && $urandom_range(99) < 18) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic lookup(longint row, int di, int dj, int dk);
      req_type r;
      r.row     = ROW_W'(row);
      r.delta_i = DELTA_W'(di);
      r.delta_j = DELTA_W'(dj);
      r.delta_k = DELTA_W'(dk);
      send_beat(r);
   endtask

   // csr write; caller drops csr_we after the group
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= EXT_W'(val);
      @(negedge clock);
   endtask

   // stop sending and let the pipe empty out
   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic longint sat(int v);
      return (v > DEF_MAX_EXTENT) ? DEF_MAX_EXTENT : v;
   endfunction

   task automatic set_grid(int x, int y, int z);
      csr_write(CSR_EXTENT_X, x);
      csr_write(CSR_EXTENT_Y, y);
      csr_write(CSR_EXTENT_Z, z);
      csr_we <= 0;
      @(negedge clock);
      ex = sat(x);
      ey = sat(y);
      ez = sat(z);
      cells = ex * ey * ez;
   endtask

   function automatic int pick_delta(longint extent);
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return $urandom_range(4) - 2;             // stencil reach
      if (sel < 80) return $urandom_range(2 * extent) - extent; // anywhere near the box
      return $urandom_range(4095) - 2048;                      // full 12-bit range
   endfunction

   task automatic random_lookups(int n);
      longint row;
      repeat (n) begin
         if (cells > 0 && $urandom_range(99) < 85) row = {$urandom, $urandom} % cells;
         else row = $urandom;
         lookup(row, pick_delta(ex), pick_delta(ey), pick_delta(ez));
      end
   endtask

   initial begin
      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      csr_we    = 0;
      csr_index = CSR_EXTENT_X;
      csr_wdata = '0;
      no_idle   = 0;
      ex = 1; ey = 1; ez = 1; cells = 1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // reset extents: single cell grid
      lookup(0, 0, 0, 0);
      lookup(1, 0, 0, 0);
      lookup(0, 1, 0, -1);
      drain();

      // small box, directed corners and edges
      set_grid(4, 3, 2);
      lookup(0, 0, 0, 0);
      lookup(23, 0, 0, 0);          // last cell
      lookup(24, 0, 0, 0);          // first row past the grid
      lookup(30'h3FFF_FFFF, 0, 0, 0);
      lookup(0, -1, 0, 0);          // step off low face
      lookup(0, 0, -1, 0);
      lookup(0, 0, 0, -1);
      lookup(23, 1, 0, 0);          // step off high face
      lookup(23, 0, 1, 0);
      lookup(23, 0, 0, 1);
      lookup(0, 3, 2, 1);           // opposite corner
      lookup(5, -2048, 2047, 0);    // offset extremes
      lookup(5, -1024, 1024, 0);
      lookup(5, 1, 1, 1);
      lookup(10, -1, -1, -1);
      drain();                      // sender holds off until all results are in

      random_lookups(160);
      drain();

      set_grid(1024, 1024, 1024);   // full 2^30 grid
      lookup(30'h3FFF_FFFF, 0, 0, 0);
      lookup(30'h3FFF_FFFF, -1023, -1023, -1023);
      lookup(0, 1023, 1023, 1023);
      lookup(0, 1024, 0, 0);
      random_lookups(160);
      drain();

      set_grid(2047, 1, 7);         // oversized x saturates
      csr_write(CSR_UNMAPPED, 5);   // ignored
      csr_we <= 0;
      @(negedge clock);
      no_idle = 1;                  // long stretch at full rate
      random_lookups(200);
      no_idle = 0;
      drain();

      set_grid(0, 5, 5);            // empty grid
      random_lookups(60);
      drain();

      set_grid(17, 33, 9);
      random_lookups(200);
      drain();

      set_grid(1024, 1, 1);
      random_lookups(160);
      drain();

      set_grid(3, 1024, 2);
      random_lookups(160);
      drain();

      set_grid(1, 1, 1);
      random_lookups(280);
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
